>>> src/uri_percent_codec_macros.svh
// assertion macros for the percent codec
`ifndef URI_PERCENT_CODEC_MACROS_SVH
`define URI_PERCENT_CODEC_MACROS_SVH

`ifndef SYNTHESIS
`define UPC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("upc assertion failed");
`define UPC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("upc assertion failed");
`else
`define UPC_ASSERT(lbl, prop)
`define UPC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> src/upc_pkg.sv
`default_nettype none
package upc_pkg;

    localparam logic [1:0] PH_PLAIN   = 2'd0;
    localparam logic [1:0] PH_PERCENT = 2'd1;
    localparam logic [1:0] PH_DIGIT   = 2'd2;
    localparam logic [1:0] PH_SWALLOW = 2'd3;

    localparam logic [1:0] ST_DATA    = 2'd0;
    localparam logic [1:0] ST_TRUNC   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [15:0][7:0] HEX_UP = {
        "F", "E", "D", "C", "B", "A", "9", "8",
        "7", "6", "5", "4", "3", "2", "1", "0"
    };

    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic [1:0]      status;
        logic            eos;
    } t_job;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c inside {["a":"z"], ["A":"Z"], ["0":"9"]});
    endfunction

    function automatic logic is_mark(input logic [7:0] c);
        return (c inside {"-", "_", ".", "!", "~", "*", "'", "(", ")"});
    endfunction

    function automatic logic is_resv(input logic [7:0] c);
        return (c inside {";", "/", "?", ":", "@", "&", "=", "+", "$", ",", "#"});
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {["0":"9"], ["a":"f"], ["A":"F"]});
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c inside {["0":"9"]}) begin
            v = c - 8'h30;
        end else if (c inside {["a":"f"]}) begin
            v = c - 8'h57;
        end else if (c inside {["A":"F"]}) begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

endpackage
`default_nettype wire

>>> src/upc_in_if.sv
`default_nettype none
interface upc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] in_byte;
    logic       last_in;

    modport source (output valid, output mode, output in_byte, output last_in, input ready);
    modport sink (input valid, input mode, input in_byte, input last_in, output ready);
endinterface
`default_nettype wire

>>> src/upc_out_if.sv
`default_nettype none
interface upc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       run_last;
    logic       end_of_string;

    modport source (output valid, output out_byte, output status, output run_last,
                    output end_of_string, input ready);
    modport sink (input valid, input out_byte, input status, input run_last,
                  input end_of_string, output ready);
endinterface
`default_nettype wire

>>> src/upc_front.sv
`default_nettype none
`include "uri_percent_codec_macros.svh"
module upc_front
    import upc_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    upc_in_if.sink     i_req,
    input  wire        i_q_full,
    output logic       o_push,
    output t_job       o_job
);

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_first, n_first;
    logic [1:0] r_err, n_err;
    logic       accept;
    logic       full;
    logic [7:0] c;
    logic [7:0] v;
    t_job       job;

    assign i_req.ready = !i_q_full;
    assign accept = i_req.valid && !i_q_full;
    assign c = i_req.in_byte;
    assign full = i_req.mode[0];
    assign v = {hex_val(r_first), hex_val(c)};

    always_comb begin
        n_phase = r_phase;
        n_first = r_first;
        n_err = r_err;
        job.bytes = '0;
        job.cnt = 2'd0;
        job.status = ST_DATA;
        job.eos = i_req.last_in;
        case (r_phase)
            PH_PLAIN: begin
                if (!i_req.mode[1]) begin
                    if (c != 8'd0 && (is_alnum(c) || is_mark(c) || (full && is_resv(c)))) begin
                        job.bytes[0] = c;
                        job.cnt = 2'd1;
                    end else begin
                        job.bytes[0] = "%";
                        job.bytes[1] = HEX_UP[c[7:4]];
                        job.bytes[2] = HEX_UP[c[3:0]];
                        job.cnt = 2'd3;
                    end
                end else if (c != "%") begin
                    job.bytes[0] = c;
                    job.cnt = 2'd1;
                end else if (i_req.last_in) begin
                    job.cnt = 2'd1;
                    job.status = ST_TRUNC;
                end else begin
                    n_phase = PH_PERCENT;
                end
            end
            PH_PERCENT: begin
                if (i_req.last_in) begin
                    job.cnt = 2'd1;
                    job.status = ST_TRUNC;
                end else begin
                    n_first = c;
                    n_phase = PH_DIGIT;
                end
            end
            PH_DIGIT: begin
                if (!is_hex(r_first) || !is_hex(c)) begin
                    if (i_req.last_in) begin
                        job.cnt = 2'd1;
                        job.status = ST_INVALID;
                    end else begin
                        n_err = ST_INVALID;
                        n_phase = PH_SWALLOW;
                    end
                end else begin
                    if (v == 8'd0 || (full && is_resv(v))) begin
                        job.bytes[0] = "%";
                        job.bytes[1] = r_first;
                        job.bytes[2] = c;
                        job.cnt = 2'd3;
                    end else begin
                        job.bytes[0] = v;
                        job.cnt = 2'd1;
                    end
                    n_phase = PH_PLAIN;
                    n_first = 8'd0;
                end
            end
            default: begin
                if (i_req.last_in) begin
                    job.cnt = 2'd1;
                    job.status = r_err;
                end
            end
        endcase
        if (i_req.last_in) begin
            n_phase = PH_PLAIN;
            n_first = 8'd0;
            n_err = ST_DATA;
        end
    end

    assign o_push = accept && (job.cnt != 2'd0);
    assign o_job = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_first <= 8'd0;
            r_err <= ST_DATA;
        end else if (accept) begin
            r_phase <= n_phase;
            r_first <= n_first;
            r_err <= n_err;
        end
    end

    `UPC_ASSERT(a_swallow_err, (r_phase == PH_SWALLOW) |-> (r_err == ST_INVALID))
    `UPC_ASSERT(a_last_clears, (accept && i_req.last_in) |=> (r_phase == PH_PLAIN))

endmodule
`default_nettype wire

>>> src/upc_queue.sv
`default_nettype none
`include "uri_percent_codec_macros.svh"
module upc_queue
    import upc_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_push,
    input  t_job       i_job,
    input  wire        i_pop,
    output logic       o_full,
    output logic       o_valid,
    output t_job       o_job
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_pop;

    assign o_full = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job = r_mem[r_rd];
    assign do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `UPC_ASSERT(a_no_overflow, i_push |-> (!o_full || do_pop))
    `UPC_ASSERT(a_cnt_bound, r_cnt <= QCNT_W'(QDEPTH))

endmodule
`default_nettype wire

>>> src/upc_back.sv
`default_nettype none
`include "uri_percent_codec_macros.svh"
module upc_back
    import upc_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_q_valid,
    input  t_job       i_q_job,
    output logic       o_pop,
    upc_out_if.source  o_res
);

    t_job       r_job;
    logic       r_have;
    logic [1:0] r_idx;
    logic       r_ovalid;
    logic [7:0] r_obyte;
    logic [1:0] r_ostatus;
    logic       r_orun;
    logic       r_oeos;
    logic       can_emit;
    logic       emit;
    logic       at_end;

    assign can_emit = !r_ovalid || o_res.ready;
    assign emit = r_have && can_emit;
    assign at_end = (r_idx == r_job.cnt - 2'd1);
    assign o_pop = i_q_valid && (!r_have || (emit && at_end));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_idx <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_have <= 1'b1;
                r_idx <= 2'd0;
            end else if (emit) begin
                if (at_end) begin
                    r_have <= 1'b0;
                end
                r_idx <= r_idx + 2'd1;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
        if (emit) begin
            r_obyte <= r_job.bytes[r_idx];
            r_ostatus <= r_job.status;
            r_orun <= at_end;
            r_oeos <= r_job.eos;
        end
    end

    assign o_res.valid = r_ovalid;
    assign o_res.out_byte = r_obyte;
    assign o_res.status = r_ostatus;
    assign o_res.run_last = r_orun;
    assign o_res.end_of_string = r_oeos;

    `UPC_ASSERT(a_idx_in_job, r_have |-> (r_idx < r_job.cnt))

endmodule
`default_nettype wire

>>> src/uri_percent_codec.sv
`default_nettype none
// Streaming URI percent encoder and decoder. Each request carries one string byte, its last
// flag and a mode (encode or decode, component or full URI); each result carries one output
// byte or an error status for a bad escape, which comes on the string's last item. A front
// stage classifies one request per cycle while the queue is not full and hands a job of one
// or three bytes into a two-entry queue; the back serialiser sends one result per cycle
// through an output register while the receiver is ready. Items that give no result (the
// start of an escape, swallowed bytes) push no job. The first result of a request passes
// through the queue entry, the back's job register and the output register.
module uri_percent_codec
    import upc_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    upc_in_if.sink     i_req,
    upc_out_if.source  o_res
);

    logic q_full;
    logic push;
    t_job push_job;
    logic pop;
    logic q_valid;
    t_job q_job;

    upc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    upc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    upc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (q_job),
        .o_pop     (pop),
        .o_res     (o_res)
    );

endmodule
`default_nettype wire

>>> dv/uri_percent_codec_test.sv
module uri_percent_codec_test;
    import upc_pkg::*;

    localparam logic [1:0] MODE_ENC_COMP = 2'd0;
    localparam logic [1:0] MODE_ENC_FULL = 2'd1;
    localparam logic [1:0] MODE_DEC_COMP = 2'd2;
    localparam logic [1:0] MODE_DEC_FULL = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  in_byte;
        logic        last_in;
        logic        typed;
        logic [1:0]  n_res;
        logic [23:0] exp_bytes;
        logic [1:0]  exp_status;
    } codec_req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       run_last;
        logic       end_of_string;
    } codec_res_t;

    logic clk;
    logic rst_n;

    upc_in_if  req_if ();
    upc_out_if res_if ();

    uri_percent_codec i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    string mark_chars  = "-_.!~*'()";
    string resv_chars  = ";/?:@&=+$,#";
    string digit_chars = "0123456789abcdefABCDEF";

    codec_res_t  pending_res[$];
    codec_req_t  str_q[$];
    codec_req_t  dir_tab[27];
    codec_req_t  cur_req;
    int          errors = 0;
    bit          hold_off_req = 1'b0;

    logic [1:0] esc_phase   = PH_PLAIN;
    logic [7:0] first_digit = 8'd0;
    logic [1:0] held_err    = ST_DATA;

    function automatic bit in_chars(string chars, logic [7:0] c);
        for (int i = 0; i < chars.len(); i++)
            if (chars[i] == c) return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit is_alnum_byte(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
    endfunction

    function automatic bit is_hex_byte(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] nibble_of(logic [7:0] c);
        if (c <= "9") return 4'(c - "0");
        if (c >= "a") return 4'(c - "a" + 10);
        return 4'(c - "A" + 10);
    endfunction

    function automatic logic [7:0] hex_char_of(logic [3:0] v);
        return (v < 10) ? 8'("0" + v) : 8'("A" + v - 10);
    endfunction

    // percent codec prediction, one request in, up to three results out
    task automatic predict_codec(input logic [1:0] mode, input logic [7:0] c, input logic last,
                                 output int n, output logic [2:0][7:0] ob,
                                 output logic [1:0] st);
        logic       full;
        logic [7:0] v;
        full = mode[0];
        n = 0;
        ob = '0;
        st = ST_DATA;
        if (esc_phase == PH_PLAIN && !mode[1]) begin
            if (c != 8'd0 && (is_alnum_byte(c) || in_chars(mark_chars, c) ||
                (full && in_chars(resv_chars, c)))) begin
                n = 1;
                ob[0] = c;
            end else begin
                n = 3;
                ob[0] = "%";
                ob[1] = hex_char_of(c[7:4]);
                ob[2] = hex_char_of(c[3:0]);
            end
        end else if (esc_phase == PH_PLAIN) begin
            if (c != "%") begin
                n = 1;
                ob[0] = c;
            end else if (last) begin
                n = 1;
                st = ST_TRUNC;
            end else begin
                esc_phase = PH_PERCENT;
            end
        end else if (esc_phase == PH_PERCENT) begin
            if (last) begin
                n = 1;
                st = ST_TRUNC;
            end else begin
                first_digit = c;
                esc_phase = PH_DIGIT;
            end
        end else if (esc_phase == PH_DIGIT) begin
            if (!is_hex_byte(first_digit) || !is_hex_byte(c)) begin
                if (last) begin
                    n = 1;
                    st = ST_INVALID;
                end else begin
                    held_err = ST_INVALID;
                    esc_phase = PH_SWALLOW;
                end
            end else begin
                v = {nibble_of(first_digit), nibble_of(c)};
                if (v == 8'd0 || (full && in_chars(resv_chars, v))) begin
                    n = 3;
                    ob[0] = "%";
                    ob[1] = first_digit;
                    ob[2] = c;
                end else begin
                    n = 1;
                    ob[0] = v;
                end
                esc_phase = PH_PLAIN;
                first_digit = 8'd0;
            end
        end else if (last) begin
            n = 1;
            st = held_err;
        end
        if (last) begin
            esc_phase = PH_PLAIN;
            first_digit = 8'd0;
            held_err = ST_DATA;
        end
    endtask

    always @(posedge clk) begin
        int               n;
        logic [2:0][7:0]  ob;
        logic [1:0]       st;
        codec_res_t       want;
        if (rst_n && req_if.valid && req_if.ready) begin
            predict_codec(req_if.mode, req_if.in_byte, req_if.last_in, n, ob, st);
            if (cur_req.typed) begin
                n = cur_req.n_res;
                st = cur_req.exp_status;
                for (int k = 0; k < n; k++)
                    ob[k] = cur_req.exp_bytes[8 * (n - 1 - k) +: 8];
            end
            for (int k = 0; k < n; k++)
                pending_res.push_back('{ob[k], st, logic'(k == n - 1), req_if.last_in});
        end
        if (rst_n && res_if.valid && res_if.ready) begin
            if (pending_res.size() == 0) begin
                $error("unexpected result: out_byte %02h status %0d",
                       res_if.out_byte, res_if.status);
                errors++;
            end else begin
                want = pending_res.pop_front();
                if (res_if.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte, res_if.out_byte);
                    errors++;
                end
                if (res_if.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, res_if.status);
                    errors++;
                end
                if (res_if.run_last !== want.run_last) begin
                    $error("run_last: expected %0b, got %0b", want.run_last, res_if.run_last);
                    errors++;
                end
                if (res_if.end_of_string !== want.end_of_string) begin
                    $error("end_of_string: expected %0b, got %0b",
                           want.end_of_string, res_if.end_of_string);
                    errors++;
                end
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 6))
            0: return 8'($urandom_range(1, 255));
            1: return 8'($urandom_range("a", "z"));
            2: return 8'($urandom_range("A", "Z"));
            3: return 8'($urandom_range("0", "9"));
            4: return mark_chars[$urandom_range(0, mark_chars.len() - 1)];
            5: return resv_chars[$urandom_range(0, resv_chars.len() - 1)];
            default: return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(8'h80, 8'hFF))
                                                       : 8'($urandom_range(1, 8'h20));
        endcase
    endfunction

    function automatic logic [7:0] digit_for(logic [3:0] v);
        logic [7:0] d;
        d = hex_char_of(v);
        if (v > 9 && $urandom_range(0, 1) != 0) d = d + 8'h20;
        return d;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] d;
        do d = rand_byte(); while (is_hex_byte(d));
        return d;
    endfunction

    function automatic codec_req_t plain_req(logic [1:0] mode, logic [7:0] c);
        return '{mode, c, 1'b0, 1'b0, 2'd0, 24'd0, ST_DATA};
    endfunction

    task automatic push_escape(input logic [1:0] m, input bit mixed, input bit broken);
        logic [7:0] v, d1, d2;
        if ($urandom_range(0, 4) == 0)
            v = ($urandom_range(0, 3) == 0) ? 8'h00
                                           : resv_chars[$urandom_range(0, resv_chars.len() - 1)];
        else
            v = 8'($urandom_range(0, 255));
        d1 = ($urandom_range(0, 3) == 0) ? digit_chars[$urandom_range(0, 21)] : digit_for(v[7:4]);
        d2 = digit_for(v[3:0]);
        if (broken) begin
            if ($urandom_range(0, 1) != 0) d1 = non_hex_byte();
            else d2 = non_hex_byte();
        end
        str_q.push_back(plain_req(m, "%"));
        str_q.push_back(plain_req(mixed ? 2'($urandom_range(0, 3)) : m, d1));
        str_q.push_back(plain_req(mixed ? 2'($urandom_range(0, 3)) : m, d2));
    endtask

    task automatic build_string();
        int         len, kind, sel;
        logic [1:0] m;
        logic [7:0] c;
        bit         mixed;
        str_q.delete();
        m = 2'($urandom_range(0, 3));
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
        kind = $urandom_range(0, 9);
        mixed = ($urandom_range(0, 5) == 0);
        while (str_q.size() < len) begin
            if (kind == 0) begin
                // noise: any mode, escapes started at random
                c = ($urandom_range(0, 3) == 0) ? 8'("%") : rand_byte();
                str_q.push_back(plain_req(2'($urandom_range(0, 3)), c));
            end else if (!m[1]) begin
                str_q.push_back(plain_req(mixed ? 2'($urandom_range(0, 1)) : m, rand_byte()));
            end else begin
                sel = $urandom_range(0, 9);
                if (sel < 5) begin
                    do c = rand_byte(); while (c == "%");
                    str_q.push_back(plain_req(m, c));
                end else begin
                    push_escape(m, mixed, sel == 9);
                end
            end
        end
        if (kind != 0 && m[1] && $urandom_range(0, 7) == 0) begin
            // string cut short inside an escape
            str_q.push_back(plain_req(m, "%"));
            if ($urandom_range(0, 1) != 0) str_q.push_back(plain_req(m, rand_byte()));
        end
        str_q[str_q.size() - 1].last_in = 1'b1;
    endtask

    task automatic send_req(input codec_req_t it, input bit calm);
        int g;
        g = calm ? 0 : gap_len();
        repeat (g) begin
            @(negedge clk);
            req_if.valid <= 1'b0;
        end
        @(negedge clk);
        req_if.valid   <= 1'b1;
        req_if.mode    <= it.mode;
        req_if.in_byte <= it.in_byte;
        req_if.last_in <= it.last_in;
        cur_req        <= it;
        do @(posedge clk); while (!req_if.ready);
    endtask

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        int stall_left, run_left;
        bit held_once;
        stall_left = 0;
        run_left = 0;
        held_once = 1'b0;
        res_if.ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_req && !held_once) begin
                held_once = 1'b1;
                stall_left = 250;
                run_left = 1;
            end
            if (stall_left == 0 && run_left == 0) begin
                stall_left = gap_len();
                run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                       : $urandom_range(1, 12);
            end
            if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
                run_left--;
            end
        end
    end

    initial begin
        #4000000;
        $display("FAIL uri_percent_codec");
        $finish;
    end

    initial begin
        int sent, w;
        bit calm, held, drained;
        rst_n          <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.mode    <= MODE_ENC_COMP;
        req_if.in_byte <= 8'h01;
        req_if.last_in <= 1'b0;
        cur_req        <= '0;
        dir_tab = '{
            '{MODE_ENC_COMP, "a",   1'b0, 1'b1, 2'd1, 24'("a"), ST_DATA},
            '{MODE_ENC_COMP, 8'h01, 1'b0, 1'b1, 2'd3, "%01",    ST_DATA},
            '{MODE_ENC_FULL, 8'hFF, 1'b0, 1'b1, 2'd3, "%FF",    ST_DATA},
            '{MODE_ENC_COMP, "/",   1'b0, 1'b0, 2'd0, 24'd0,    ST_DATA},
            '{MODE_ENC_FULL, "/",   1'b0, 1'b0, 2'd0, 24'd0,    ST_DATA},
            '{MODE_ENC_COMP, 8'h60, 1'b1, 1'b1, 2'd3, "%60",    ST_DATA},
            '{MODE_DEC_COMP, "%",   1'b0, 1'b0, 2'd0, 24'd0,    ST_DATA},
            '{MODE_DEC_COMP, "4",   1'b0, 1'b0, 2'd0, 24'd0,    ST_DATA},
            '{MODE_DEC_COMP, "1",   1'b0, 1'b0, 2'd0, 24'd0,    ST_DATA},
            // mode changes mid escape, reserved set taken from the closing digit
            '{MODE_DEC_FULL, "%",   1'b0, 1'b0, 2'd0, 24'd0,    ST_DATA},
            '{MODE_ENC_COMP, "2",   1'b0, 1'b0, 2'd0, 24'd0,    ST_DATA},
            '{MODE_ENC_FULL, "f",   1'b0, 1'b0, 2'd0, 24'd0,    ST_DATA},
            '{MODE_DEC_COMP, "%",   1'b0, 1'b0, 2'd0, 24'd0,    ST_DATA},
            '{MODE_DEC_COMP, "0",   1'b0, 1'b0, 2'd0, 24'd0,    ST_DATA},
            '{MODE_DEC_COMP, "0",   1'b1, 1'b0, 2'd0, 24'd0,    ST_DATA},
            // bad first digit, rest of string swallowed
            '{MODE_DEC_COMP, "%",   1'b0, 1'b0, 2'd0, 24'd0,    ST_DATA},
            '{MODE_DEC_COMP, "G",   1'b0, 1'b0, 2'd0, 24'd0,    ST_DATA},
            '{MODE_DEC_COMP, "1",   1'b0, 1'b0, 2'd0, 24'd0,    ST_DATA},
            '{MODE_DEC_COMP, "x",   1'b1, 1'b1, 2'd1, 24'd0,    ST_INVALID},
            '{MODE_DEC_FULL, "%",   1'b1, 1'b1, 2'd1, 24'd0,    ST_TRUNC},
            '{MODE_DEC_COMP, "%",   1'b0, 1'b0, 2'd0, 24'd0,    ST_DATA},
            '{MODE_DEC_COMP, "G",   1'b1, 1'b1, 2'd1, 24'd0,    ST_TRUNC},
            '{MODE_DEC_FULL, "%",   1'b0, 1'b0, 2'd0, 24'd0,    ST_DATA},
            '{MODE_DEC_FULL, "1",   1'b0, 1'b0, 2'd0, 24'd0,    ST_DATA},
            '{MODE_DEC_FULL, "Z",   1'b1, 1'b1, 2'd1, 24'd0,    ST_INVALID},
            '{MODE_DEC_COMP, 8'hFF, 1'b0, 1'b0, 2'd0, 24'd0,    ST_DATA},
            '{MODE_DEC_FULL, 8'h01, 1'b1, 1'b0, 2'd0, 24'd0,    ST_DATA}
        };
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i]) send_req(dir_tab[i], 1'b0);

        sent = 0;
        held = 1'b0;
        drained = 1'b0;
        while (sent < 460) begin
            if (!held && sent >= 150) begin
                // receiver holds off while a burst of encode requests piles up
                held = 1'b1;
                hold_off_req = 1'b1;
                str_q.delete();
                repeat (30) str_q.push_back(plain_req(MODE_ENC_COMP, rand_byte()));
                str_q[str_q.size() - 1].last_in = 1'b1;
                calm = 1'b1;
            end else begin
                if (!drained && sent >= 300) begin
                    drained = 1'b1;
                    @(negedge clk);
                    req_if.valid <= 1'b0;
                    while (pending_res.size() != 0) @(posedge clk);
                end
                build_string();
                calm = ($urandom_range(0, 3) == 0);
            end
            foreach (str_q[k]) send_req(str_q[k], calm);
            sent += str_q.size();
        end
        @(negedge clk);
        req_if.valid <= 1'b0;

        for (w = 0; w < 20000 && pending_res.size() != 0; w++) @(posedge clk);
        repeat (20) @(posedge clk);
        if (pending_res.size() != 0)
            $error("%0d expected results never arrived", pending_res.size());
        if (errors == 0 && pending_res.size() == 0) begin
            $display("PASS uri_percent_codec");
        end else begin
            $display("FAIL uri_percent_codec");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/upc_pkg.sv
src/upc_in_if.sv
src/upc_out_if.sv
src/upc_front.sv
src/upc_queue.sv
src/upc_back.sv
src/uri_percent_codec.sv
dv/uri_percent_codec_test.sv
